// File: hw/rtl/cau_pkg.sv
// Shared types, operation codes and helper functions of the complex arithmetic unit.
`default_nettype none

package cau_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int SUM_W         = 65;   // exact sum of two 64-bit products
   localparam int LIN_W         = 33;   // sum of two 32-bit operands
   localparam int DEN_W         = 64;   // squared norm, at most 2^63
   localparam int Q_BITS        = 33;   // quotient bits kept; larger quotients clamp
   localparam int NUM_MULT      = 6;

   typedef enum logic [3:0] {
      OP_ADD     = 4'd0,
      OP_SUB     = 4'd1,
      OP_MUL     = 4'd2,
      OP_DIV     = 4'd3,
      OP_NEG     = 4'd4,
      OP_CONJ    = 4'd5,
      OP_SQUARE  = 4'd6,
      OP_NORMSQ  = 4'd7,
      OP_RECIP   = 4'd8,
      OP_COMPARE = 4'd9,
      OP_SCALE   = 4'd10,
      OP_SHRINK  = 4'd11
   } op_type;

   typedef struct packed {
      logic [3:0]         operation;
      logic signed [31:0] a_real;
      logic signed [31:0] a_imag;
      logic signed [31:0] b_real;
      logic signed [31:0] b_imag;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_real;
      logic signed [31:0] result_imag;
      logic               mag_less;
      logic               mag_equal;
      logic               mag_greater;
      logic               parts_equal;
      logic               divide_by_zero;
      logic               saturated;
   } rsp_type;

   // Result fields settled before the divider, plus what the divider tail needs.
   typedef struct packed {
      logic signed [31:0] rr;
      logic signed [31:0] ri;
      logic               ml;
      logic               me;
      logic               mg;
      logic               pe;
      logic               dz;
      logic               sat;
      logic               is_div;
      logic               neg_re;
      logic               neg_im;
   } side_type;

   typedef struct packed {
      logic               sat;
      logic signed [31:0] val;
   } clamp_type;

   function automatic clamp_type clamp32(input logic signed [SUM_W-1:0] v);
      clamp_type c;
      c.sat = 1'b0;
      c.val = v[31:0];
      if (!v[SUM_W-1] && (v[SUM_W-2:31] != '0)) begin
         c.sat = 1'b1;
         c.val = 32'sh7FFF_FFFF;
      end else if (v[SUM_W-1] && (v[SUM_W-2:31] != '1)) begin
         c.sat = 1'b1;
         c.val = 32'sh8000_0000;
      end
      return c;
   endfunction

   // Apply sign to a truncated quotient magnitude and clamp.
   function automatic clamp_type div_pack(input logic neg, input logic ovf,
                                          input logic [Q_BITS-1:0] q);
      clamp_type c;
      c.sat = 1'b0;
      c.val = q[31:0];
      if (!neg || (q == '0 && !ovf)) begin
         if (ovf || q > Q_BITS'(33'h0_7FFF_FFFF)) begin
            c.sat = 1'b1;
            c.val = 32'sh7FFF_FFFF;
         end
      end else begin
         if (ovf || q > Q_BITS'(33'h0_8000_0000)) begin
            c.sat = 1'b1;
            c.val = 32'sh8000_0000;
         end else begin
            c.val = ~q[31:0] + 32'd1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/complex_arithmetic_unit_top.sv
// Top level of the complex arithmetic unit: multiplier, adder and divider pipeline.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+-------------------------------
//   req     | in  | req_valid/req_stall | cau_pkg::req_type (op, a, b)
//   rsp     | out | rsp_valid/rsp_stall | cau_pkg::rsp_type (result, flags)
//
// One item enters per cycle while req_stall is low.
// Most of the pipeline is the 33-step restoring divider, one quotient bit per stage.
// Synchronous reset clears all valid bits; payload registers are not reset.
// A stalled result sits in the output register; one more item lands in a skid
// register, after which req_stall rises and the whole pipeline holds.
`default_nettype none

module complex_arithmetic_unit_top #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire cau_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output cau_pkg::rsp_type      rsp_item
);

   localparam int DVD_W = cau_pkg::DEN_W + 2 * FRAC_BITS;
   localparam int CMP_W = (DVD_W > cau_pkg::DEN_W + cau_pkg::Q_BITS) ?
                          DVD_W : cau_pkg::DEN_W + cau_pkg::Q_BITS;
   localparam int QB    = cau_pkg::Q_BITS;

   logic pipe_en;

   // ---------------- stage A: operand capture ----------------
   logic             a_valid_ff;
   cau_pkg::req_type a_req_ff;

   // ---------------- stage B: products and linear terms ----------------
   logic signed [31:0]               x_in [cau_pkg::NUM_MULT];
   logic signed [31:0]               y_in [cau_pkg::NUM_MULT];
   logic signed [63:0]               b_p_ff [cau_pkg::NUM_MULT];
   logic signed [cau_pkg::LIN_W-1:0] lin_re_in, lin_im_in, b_lin_re_ff, b_lin_im_ff;
   logic [31:0]                      lin_den_in, b_lin_den_ff;
   logic                             pe_in, b_pe_ff, b_valid_ff;
   cau_pkg::op_type                  a_op, b_op_ff;

   // ---------------- stage C: exact sums ----------------
   logic signed [cau_pkg::SUM_W-1:0] v_re_in, v_im_in, c_v_re_ff, c_v_im_ff;
   logic [cau_pkg::DEN_W-1:0]        den_in, c_den_ff;
   logic                             c_valid_ff, c_pe_ff;
   cau_pkg::op_type                  c_op_ff;

   // ---------------- stage D: rounding, compare, dividend setup ----------------
   logic signed [cau_pkg::SUM_W-1:0] fl_re, fl_im;
   cau_pkg::clamp_type               cl_re, cl_im, cr_re, cr_im;
   logic [cau_pkg::DEN_W-1:0]        mag_re, mag_im;
   logic [DVD_W-1:0]                 dvd_re_in, dvd_im_in, d_dvd_re_ff, d_dvd_im_ff;
   cau_pkg::side_type                side_in, d_side_ff;
   logic [cau_pkg::DEN_W-1:0]        d_den_ff;
   logic                             d_valid_ff;

   // ---------------- divider stages, index 0 is the setup stage ----------------
   logic                      dv_valid_ff [QB+1];
   cau_pkg::side_type         dv_side_ff  [QB+1];
   logic [cau_pkg::DEN_W-1:0] dv_den_ff   [QB+1];
   logic [cau_pkg::DEN_W-1:0] dv_r_re_ff  [QB+1];
   logic [cau_pkg::DEN_W-1:0] dv_r_im_ff  [QB+1];
   logic [QB-1:0]             dv_lq_re_ff [QB+1];   // dividend low bits in, quotient out
   logic [QB-1:0]             dv_lq_im_ff [QB+1];
   logic                      dv_ovf_re_ff[QB+1];
   logic                      dv_ovf_im_ff[QB+1];
   logic [cau_pkg::DEN_W-1:0] r_re_in  [QB+1];
   logic [cau_pkg::DEN_W-1:0] r_im_in  [QB+1];
   logic [QB-1:0]             lq_re_in [QB+1];
   logic [QB-1:0]             lq_im_in [QB+1];
   logic                      ovf_re_in, ovf_im_in;
   logic [cau_pkg::DEN_W:0]   t_re [QB];
   logic [cau_pkg::DEN_W:0]   t_im [QB];

   // ---------------- output register and skid ----------------
   cau_pkg::rsp_type   fin_item;
   cau_pkg::clamp_type q_re, q_im;
   logic               rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;
   cau_pkg::rsp_type   rsp_data_ff, rsp_data_in, skid_data_ff, skid_data_in;

   assign pipe_en   = !skid_valid_ff;
   assign req_stall = skid_valid_ff | reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_data_ff;

   // ---- A -> B: multiplier operand select, linear terms ----
   assign a_op = cau_pkg::op_type'(a_req_ff.operation);

   always_comb begin
      for (int k = 0; k < cau_pkg::NUM_MULT; k++) begin
         x_in[k] = '0;
         y_in[k] = '0;
      end
      lin_re_in  = '0;
      lin_im_in  = '0;
      lin_den_in = a_req_ff.b_real[31] ? 32'(-a_req_ff.b_real) : 32'(a_req_ff.b_real);
      pe_in      = (a_req_ff.a_real == a_req_ff.b_real) &&
                   (a_req_ff.a_imag == a_req_ff.b_imag);
      unique case (a_op)
         cau_pkg::OP_MUL, cau_pkg::OP_DIV: begin
            x_in[0] = a_req_ff.a_real;  y_in[0] = a_req_ff.b_real;
            x_in[1] = a_req_ff.a_imag;  y_in[1] = a_req_ff.b_imag;
            x_in[2] = a_req_ff.a_imag;  y_in[2] = a_req_ff.b_real;
            x_in[3] = a_req_ff.a_real;  y_in[3] = a_req_ff.b_imag;
            x_in[4] = a_req_ff.b_real;  y_in[4] = a_req_ff.b_real;
            x_in[5] = a_req_ff.b_imag;  y_in[5] = a_req_ff.b_imag;
         end
         cau_pkg::OP_SQUARE: begin
            x_in[0] = a_req_ff.a_real;  y_in[0] = a_req_ff.a_real;
            x_in[1] = a_req_ff.a_imag;  y_in[1] = a_req_ff.a_imag;
            x_in[2] = a_req_ff.a_real;  y_in[2] = a_req_ff.a_imag;
            x_in[3] = a_req_ff.a_real;  y_in[3] = a_req_ff.a_imag;
         end
         cau_pkg::OP_NORMSQ: begin
            x_in[0] = a_req_ff.a_real;  y_in[0] = a_req_ff.a_real;
            x_in[1] = a_req_ff.a_imag;  y_in[1] = a_req_ff.a_imag;
         end
         cau_pkg::OP_RECIP: begin
            x_in[4] = a_req_ff.a_real;  y_in[4] = a_req_ff.a_real;
            x_in[5] = a_req_ff.a_imag;  y_in[5] = a_req_ff.a_imag;
            lin_re_in = cau_pkg::LIN_W'(a_req_ff.a_real);
            lin_im_in = -cau_pkg::LIN_W'(a_req_ff.a_imag);
         end
         cau_pkg::OP_COMPARE: begin
            x_in[0] = a_req_ff.a_real;  y_in[0] = a_req_ff.a_real;
            x_in[1] = a_req_ff.a_imag;  y_in[1] = a_req_ff.a_imag;
            x_in[4] = a_req_ff.b_real;  y_in[4] = a_req_ff.b_real;
            x_in[5] = a_req_ff.b_imag;  y_in[5] = a_req_ff.b_imag;
         end
         cau_pkg::OP_SCALE: begin
            x_in[0] = a_req_ff.a_real;  y_in[0] = a_req_ff.b_real;
            x_in[2] = a_req_ff.a_imag;  y_in[2] = a_req_ff.b_real;
         end
         cau_pkg::OP_ADD: begin
            lin_re_in = cau_pkg::LIN_W'(a_req_ff.a_real) + cau_pkg::LIN_W'(a_req_ff.b_real);
            lin_im_in = cau_pkg::LIN_W'(a_req_ff.a_imag) + cau_pkg::LIN_W'(a_req_ff.b_imag);
         end
         cau_pkg::OP_SUB: begin
            lin_re_in = cau_pkg::LIN_W'(a_req_ff.a_real) - cau_pkg::LIN_W'(a_req_ff.b_real);
            lin_im_in = cau_pkg::LIN_W'(a_req_ff.a_imag) - cau_pkg::LIN_W'(a_req_ff.b_imag);
         end
         cau_pkg::OP_NEG: begin
            lin_re_in = -cau_pkg::LIN_W'(a_req_ff.a_real);
            lin_im_in = -cau_pkg::LIN_W'(a_req_ff.a_imag);
         end
         cau_pkg::OP_CONJ: begin
            lin_re_in = cau_pkg::LIN_W'(a_req_ff.a_real);
            lin_im_in = -cau_pkg::LIN_W'(a_req_ff.a_imag);
         end
         cau_pkg::OP_SHRINK: begin
            // fold the factor's sign into the numerator, divide by its magnitude
            lin_re_in = a_req_ff.b_real[31] ? -cau_pkg::LIN_W'(a_req_ff.a_real)
                                            :  cau_pkg::LIN_W'(a_req_ff.a_real);
            lin_im_in = a_req_ff.b_real[31] ? -cau_pkg::LIN_W'(a_req_ff.a_imag)
                                            :  cau_pkg::LIN_W'(a_req_ff.a_imag);
         end
         default: begin
         end
      endcase
   end

   // ---- B -> C: exact sums of products, divisor ----
   always_comb begin
      v_re_in = '0;
      v_im_in = '0;
      den_in  = '0;
      unique case (b_op_ff)
         cau_pkg::OP_MUL, cau_pkg::OP_SQUARE, cau_pkg::OP_SCALE: begin
            v_re_in = cau_pkg::SUM_W'(b_p_ff[0]) - cau_pkg::SUM_W'(b_p_ff[1]);
            v_im_in = cau_pkg::SUM_W'(b_p_ff[2]) + cau_pkg::SUM_W'(b_p_ff[3]);
         end
         cau_pkg::OP_NORMSQ: begin
            v_re_in = cau_pkg::SUM_W'(b_p_ff[0]) + cau_pkg::SUM_W'(b_p_ff[1]);
         end
         cau_pkg::OP_DIV: begin
            v_re_in = cau_pkg::SUM_W'(b_p_ff[0]) + cau_pkg::SUM_W'(b_p_ff[1]);
            v_im_in = cau_pkg::SUM_W'(b_p_ff[2]) - cau_pkg::SUM_W'(b_p_ff[3]);
            den_in  = $unsigned(b_p_ff[4]) + $unsigned(b_p_ff[5]);
         end
         cau_pkg::OP_COMPARE: begin
            v_re_in = cau_pkg::SUM_W'(b_p_ff[0]) + cau_pkg::SUM_W'(b_p_ff[1]);
            den_in  = $unsigned(b_p_ff[4]) + $unsigned(b_p_ff[5]);
         end
         cau_pkg::OP_RECIP: begin
            v_re_in = cau_pkg::SUM_W'(b_lin_re_ff);
            v_im_in = cau_pkg::SUM_W'(b_lin_im_ff);
            den_in  = $unsigned(b_p_ff[4]) + $unsigned(b_p_ff[5]);
         end
         cau_pkg::OP_SHRINK: begin
            v_re_in = cau_pkg::SUM_W'(b_lin_re_ff);
            v_im_in = cau_pkg::SUM_W'(b_lin_im_ff);
            den_in  = cau_pkg::DEN_W'(b_lin_den_ff);
         end
         cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_NEG, cau_pkg::OP_CONJ: begin
            v_re_in = cau_pkg::SUM_W'(b_lin_re_ff);
            v_im_in = cau_pkg::SUM_W'(b_lin_im_ff);
         end
         default: begin
         end
      endcase
   end

   // ---- C -> D: floor and clamp, magnitude compare, dividend setup ----
   assign fl_re  = c_v_re_ff >>> FRAC_BITS;
   assign fl_im  = c_v_im_ff >>> FRAC_BITS;
   assign cl_re  = cau_pkg::clamp32(c_v_re_ff);
   assign cl_im  = cau_pkg::clamp32(c_v_im_ff);
   assign cr_re  = cau_pkg::clamp32(fl_re);
   assign cr_im  = cau_pkg::clamp32(fl_im);
   assign mag_re = c_v_re_ff[cau_pkg::SUM_W-1] ? cau_pkg::DEN_W'(-c_v_re_ff)
                                               : cau_pkg::DEN_W'(c_v_re_ff);
   assign mag_im = c_v_im_ff[cau_pkg::SUM_W-1] ? cau_pkg::DEN_W'(-c_v_im_ff)
                                               : cau_pkg::DEN_W'(c_v_im_ff);

   always_comb begin
      // reciprocal scales by 2^(2F), the other quotients by 2^F
      if (c_op_ff == cau_pkg::OP_RECIP) begin
         dvd_re_in = DVD_W'(mag_re) << (2 * FRAC_BITS);
         dvd_im_in = DVD_W'(mag_im) << (2 * FRAC_BITS);
      end else begin
         dvd_re_in = DVD_W'(mag_re) << FRAC_BITS;
         dvd_im_in = DVD_W'(mag_im) << FRAC_BITS;
      end
   end

   always_comb begin
      side_in = '0;
      unique case (c_op_ff)
         cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_NEG, cau_pkg::OP_CONJ: begin
            side_in.rr  = cl_re.val;
            side_in.ri  = cl_im.val;
            side_in.sat = cl_re.sat | cl_im.sat;
         end
         cau_pkg::OP_MUL, cau_pkg::OP_SQUARE, cau_pkg::OP_NORMSQ, cau_pkg::OP_SCALE: begin
            side_in.rr  = cr_re.val;
            side_in.ri  = cr_im.val;
            side_in.sat = cr_re.sat | cr_im.sat;
         end
         cau_pkg::OP_COMPARE: begin
            side_in.ml = c_v_re_ff[cau_pkg::DEN_W-1:0] <  c_den_ff;
            side_in.me = c_v_re_ff[cau_pkg::DEN_W-1:0] == c_den_ff;
            side_in.mg = c_v_re_ff[cau_pkg::DEN_W-1:0] >  c_den_ff;
            side_in.pe = c_pe_ff;
         end
         cau_pkg::OP_DIV, cau_pkg::OP_RECIP, cau_pkg::OP_SHRINK: begin
            side_in.dz     = (c_den_ff == '0);
            side_in.is_div = (c_den_ff != '0);
            side_in.neg_re = c_v_re_ff[cau_pkg::SUM_W-1];
            side_in.neg_im = c_v_im_ff[cau_pkg::SUM_W-1];
         end
         default: begin
         end
      endcase
   end

   // ---- D -> divider setup: overflow check ----
   assign ovf_re_in = CMP_W'(d_dvd_re_ff) >= (CMP_W'(d_den_ff) << QB);
   assign ovf_im_in = CMP_W'(d_dvd_im_ff) >= (CMP_W'(d_den_ff) << QB);

   // ---- first partial remainder, then restoring divide steps, one bit per stage ----
   always_comb begin
      r_re_in[0]  = cau_pkg::DEN_W'(d_dvd_re_ff >> QB);
      r_im_in[0]  = cau_pkg::DEN_W'(d_dvd_im_ff >> QB);
      lq_re_in[0] = d_dvd_re_ff[QB-1:0];
      lq_im_in[0] = d_dvd_im_ff[QB-1:0];
      for (int s = 0; s < QB; s++) begin
         t_re[s] = {1'b0, dv_r_re_ff[s]} << 1 | (cau_pkg::DEN_W+1)'(dv_lq_re_ff[s][QB-1]);
         t_im[s] = {1'b0, dv_r_im_ff[s]} << 1 | (cau_pkg::DEN_W+1)'(dv_lq_im_ff[s][QB-1]);
         if (t_re[s] >= {1'b0, dv_den_ff[s]}) begin
            r_re_in[s+1]  = cau_pkg::DEN_W'(t_re[s] - {1'b0, dv_den_ff[s]});
            lq_re_in[s+1] = {dv_lq_re_ff[s][QB-2:0], 1'b1};
         end else begin
            r_re_in[s+1]  = t_re[s][cau_pkg::DEN_W-1:0];
            lq_re_in[s+1] = {dv_lq_re_ff[s][QB-2:0], 1'b0};
         end
         if (t_im[s] >= {1'b0, dv_den_ff[s]}) begin
            r_im_in[s+1]  = cau_pkg::DEN_W'(t_im[s] - {1'b0, dv_den_ff[s]});
            lq_im_in[s+1] = {dv_lq_im_ff[s][QB-2:0], 1'b1};
         end else begin
            r_im_in[s+1]  = t_im[s][cau_pkg::DEN_W-1:0];
            lq_im_in[s+1] = {dv_lq_im_ff[s][QB-2:0], 1'b0};
         end
      end
   end

   // ---- final: sign and clamp quotients, assemble the result item ----
   assign q_re = cau_pkg::div_pack(dv_side_ff[QB].neg_re, dv_ovf_re_ff[QB], dv_lq_re_ff[QB]);
   assign q_im = cau_pkg::div_pack(dv_side_ff[QB].neg_im, dv_ovf_im_ff[QB], dv_lq_im_ff[QB]);

   always_comb begin
      fin_item.result_real    = dv_side_ff[QB].rr;
      fin_item.result_imag    = dv_side_ff[QB].ri;
      fin_item.mag_less       = dv_side_ff[QB].ml;
      fin_item.mag_equal      = dv_side_ff[QB].me;
      fin_item.mag_greater    = dv_side_ff[QB].mg;
      fin_item.parts_equal    = dv_side_ff[QB].pe;
      fin_item.divide_by_zero = dv_side_ff[QB].dz;
      fin_item.saturated      = dv_side_ff[QB].sat;
      if (dv_side_ff[QB].is_div) begin
         fin_item.result_real = q_re.val;
         fin_item.result_imag = q_im.val;
         fin_item.saturated   = q_re.sat | q_im.sat;
      end
   end

   // ---- output register with one-entry skid ----
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = pipe_en && dv_valid_ff[QB];
            rsp_data_in  = fin_item;
         end
      end else if (pipe_en && dv_valid_ff[QB]) begin
         skid_valid_in = 1'b1;
         skid_data_in  = fin_item;
      end
   end

   // ---- valid bits ----
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         c_valid_ff    <= 1'b0;
         d_valid_ff    <= 1'b0;
         for (int s = 0; s <= QB; s++) begin
            dv_valid_ff[s] <= 1'b0;
         end
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (pipe_en) begin
            a_valid_ff     <= req_valid;
            b_valid_ff     <= a_valid_ff;
            c_valid_ff     <= b_valid_ff;
            d_valid_ff     <= c_valid_ff;
            dv_valid_ff[0] <= d_valid_ff;
            for (int s = 1; s <= QB; s++) begin
               dv_valid_ff[s] <= dv_valid_ff[s-1];
            end
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
      if (pipe_en) begin
         a_req_ff <= req_item;

         for (int k = 0; k < cau_pkg::NUM_MULT; k++) begin
            b_p_ff[k] <= x_in[k] * y_in[k];
         end
         b_op_ff      <= a_op;
         b_lin_re_ff  <= lin_re_in;
         b_lin_im_ff  <= lin_im_in;
         b_lin_den_ff <= lin_den_in;
         b_pe_ff      <= pe_in;

         c_op_ff   <= b_op_ff;
         c_v_re_ff <= v_re_in;
         c_v_im_ff <= v_im_in;
         c_den_ff  <= den_in;
         c_pe_ff   <= b_pe_ff;

         d_side_ff   <= side_in;
         d_dvd_re_ff <= dvd_re_in;
         d_dvd_im_ff <= dvd_im_in;
         d_den_ff    <= c_den_ff;

         dv_side_ff[0]   <= d_side_ff;
         dv_den_ff[0]    <= d_den_ff;
         dv_ovf_re_ff[0] <= ovf_re_in;
         dv_ovf_im_ff[0] <= ovf_im_in;
         for (int s = 0; s <= QB; s++) begin
            dv_r_re_ff[s]  <= r_re_in[s];
            dv_r_im_ff[s]  <= r_im_in[s];
            dv_lq_re_ff[s] <= lq_re_in[s];
            dv_lq_im_ff[s] <= lq_im_in[s];
         end
         for (int s = 1; s <= QB; s++) begin
            dv_side_ff[s]   <= dv_side_ff[s-1];
            dv_den_ff[s]    <= dv_den_ff[s-1];
            dv_ovf_re_ff[s] <= dv_ovf_re_ff[s-1];
            dv_ovf_im_ff[s] <= dv_ovf_im_ff[s-1];
         end
      end
   end

   // ---- assertions ----
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds an item while the output register is empty");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> (rsp_valid_ff && !skid_valid_ff))
      else $error("skid item not moved to the output register");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(dv_valid_ff[QB]))
      else $error("pipeline moved while held");

   a_mag_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_data_ff.mag_less, rsp_data_ff.mag_equal,
                                 rsp_data_ff.mag_greater}))
      else $error("more than one magnitude compare flag set");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.divide_by_zero) |->
         (rsp_data_ff.result_real == '0 && rsp_data_ff.result_imag == '0 &&
          !rsp_data_ff.saturated))
      else $error("zero divisor gave a nonzero or saturated result");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the complex arithmetic unit: random and directed items.
`timescale 1ns / 1ps

module testbench;

   typedef logic signed [127:0] wide_type;

   localparam int       FRAC       = cau_pkg::FRAC_BITS_DEF;
   localparam int       NUM_RANDOM = 400;
   localparam int       DRAIN      = 80;     // beyond the pipeline latency
   localparam int       IDLE_LIMIT = 3000;   // cycles without any handshake
   localparam wide_type MAX32      = 128'sd2147483647;
   localparam wide_type MIN32      = -128'sd2147483648;
   localparam wide_type QCAP       = 128'sd4294967296;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   cau_pkg::req_type req_item = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   cau_pkg::rsp_type rsp_item;

   cau_pkg::req_type pending_items[$];
   cau_pkg::rsp_type expected_results[$];
   int      mismatches = 0;
   int      received = 0;
   int      gap_left = 0;
   int      stall_left = 0;
   int      burst_left = 0;
   int      idle_cycles = 0;

   complex_arithmetic_unit_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Arithmetic of the unit, done at 128 bits so nothing wraps.
   // ---------------------------------------------------------------------

   // Clamp to 32 bits; bit 32 of the return flags saturation.
   function automatic logic [32:0] fit32(input wide_type v);
      if (v > MAX32) return {1'b1, 32'h7FFF_FFFF};
      if (v < MIN32) return {1'b1, 32'h8000_0000};
      return {1'b0, v[31:0]};
   endfunction

   // Truncating quotient of num * 2^sh by a positive den, capped past 2^32.
   function automatic wide_type trunc_quot(input wide_type num, input int sh,
                                           input wide_type den);
      wide_type mag;
      wide_type q;
      mag = (num < 0) ? -num : num;
      q   = (mag <<< sh) / den;
      if (q > QCAP) q = QCAP;
      return (num < 0) ? -q : q;
   endfunction

   function automatic cau_pkg::rsp_type complex_result(input cau_pkg::req_type it);
      cau_pkg::rsp_type r;
      wide_type         ar, ai, br, bi, re, im, na, nb;
      logic [32:0]      fr, fi;
      logic             has_parts;
      ar = it.a_real;
      ai = it.a_imag;
      br = it.b_real;
      bi = it.b_imag;
      r  = '0;
      re = 0;
      im = 0;
      has_parts = 1'b1;
      na = ar * ar + ai * ai;
      nb = br * br + bi * bi;
      unique case (it.operation)
         cau_pkg::OP_ADD: begin re = ar + br; im = ai + bi; end
         cau_pkg::OP_SUB: begin re = ar - br; im = ai - bi; end
         cau_pkg::OP_MUL: begin
            re = (ar * br - ai * bi) >>> FRAC;
            im = (ai * br + ar * bi) >>> FRAC;
         end
         cau_pkg::OP_DIV: begin
            if (nb == 0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               re = trunc_quot(ar * br + ai * bi, FRAC, nb);
               im = trunc_quot(ai * br - ar * bi, FRAC, nb);
            end
         end
         cau_pkg::OP_NEG:    begin re = -ar; im = -ai; end
         cau_pkg::OP_CONJ:   begin re = ar; im = -ai; end
         cau_pkg::OP_SQUARE: begin
            re = (ar * ar - ai * ai) >>> FRAC;
            im = (2 * ar * ai) >>> FRAC;
         end
         cau_pkg::OP_NORMSQ: re = na >>> FRAC;
         cau_pkg::OP_RECIP: begin
            if (na == 0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               re = trunc_quot(ar, 2 * FRAC, na);
               im = trunc_quot(-ai, 2 * FRAC, na);
            end
         end
         cau_pkg::OP_COMPARE: begin
            r.mag_less    = na < nb;
            r.mag_equal   = na == nb;
            r.mag_greater = na > nb;
            r.parts_equal = (ar == br) && (ai == bi);
         end
         cau_pkg::OP_SCALE: begin
            re = (ar * br) >>> FRAC;
            im = (ai * br) >>> FRAC;
         end
         cau_pkg::OP_SHRINK: begin
            if (br == 0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               // sign of the factor moves onto the numerator
               re = trunc_quot((br < 0) ? -ar : ar, FRAC, (br < 0) ? -br : br);
               im = trunc_quot((br < 0) ? -ai : ai, FRAC, (br < 0) ? -br : br);
            end
         end
         default: has_parts = 1'b0;   // unused codes give all zeros
      endcase
      if (has_parts) begin
         fr = fit32(re);
         fi = fit32(im);
         r.result_real = fr[31:0];
         r.result_imag = fi[31:0];
         r.saturated   = fr[32] | fi[32];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Idle lengths: mostly none or short, a few long, and bursts with none.
   // ---------------------------------------------------------------------
   function automatic int idle_length();
      int pick;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         burst_left = $urandom_range(20, 80);
         return 0;
      end
      if (pick < 50) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------------
   // Driver: a stalled item is held; otherwise the next one goes out
   // once its gap has passed.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_results.push_back(complex_result(req_item));
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_item  <= pending_items.pop_front();
               req_valid <= 1'b1;
               gap_left  <= idle_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each accepted result against the oldest prediction,
   // and throttles the result side.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cau_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            received++;
            if (expected_results.size() == 0) begin
               $error("result item with no prediction waiting");
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_item.result_real !== want.result_real) begin
                  $error("result_real expected %0d actual %0d",
                         want.result_real, rsp_item.result_real);
                  mismatches++;
               end
               if (rsp_item.result_imag !== want.result_imag) begin
                  $error("result_imag expected %0d actual %0d",
                         want.result_imag, rsp_item.result_imag);
                  mismatches++;
               end
               if (rsp_item.mag_less !== want.mag_less) begin
                  $error("mag_less expected %0b actual %0b",
                         want.mag_less, rsp_item.mag_less);
                  mismatches++;
               end
               if (rsp_item.mag_equal !== want.mag_equal) begin
                  $error("mag_equal expected %0b actual %0b",
                         want.mag_equal, rsp_item.mag_equal);
                  mismatches++;
               end
               if (rsp_item.mag_greater !== want.mag_greater) begin
                  $error("mag_greater expected %0b actual %0b",
                         want.mag_greater, rsp_item.mag_greater);
                  mismatches++;
               end
               if (rsp_item.parts_equal !== want.parts_equal) begin
                  $error("parts_equal expected %0b actual %0b",
                         want.parts_equal, rsp_item.parts_equal);
                  mismatches++;
               end
               if (rsp_item.divide_by_zero !== want.divide_by_zero) begin
                  $error("divide_by_zero expected %0b actual %0b",
                         want.divide_by_zero, rsp_item.divide_by_zero);
                  mismatches++;
               end
               if (rsp_item.saturated !== want.saturated) begin
                  $error("saturated expected %0b actual %0b",
                         want.saturated, rsp_item.saturated);
                  mismatches++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else begin
            stall_left <= idle_length();
            rsp_stall  <= 1'b0;
         end
      end
   end

   // Watchdog: no handshake on either side for too long ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Operand part: edge values, small Q16.16 numbers or any 32-bit word.
   function automatic logic [31:0] operand_part();
      logic [31:0] edges[8];
      int          pick;
      edges = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000};
      pick = $urandom_range(0, 9);
      if (pick < 2) return edges[$urandom_range(0, 7)];
      if (pick < 6) return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      return $urandom;
   endfunction

   function automatic cau_pkg::req_type make_item(input logic [3:0] op,
                                                  input logic [31:0] ar,
                                                  input logic [31:0] ai,
                                                  input logic [31:0] br,
                                                  input logic [31:0] bi);
      cau_pkg::req_type it;
      it.operation = op;
      it.a_real    = ar;
      it.a_imag    = ai;
      it.b_real    = br;
      it.b_imag    = bi;
      return it;
   endfunction

   initial begin
      cau_pkg::req_type it;
      int               pick;
      int               total_items;

      // directed: extremes, zero divisors, compare ties, unused codes
      pending_items.push_back(make_item(cau_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000,
                                        32'h1, 32'hFFFF_FFFF));
      pending_items.push_back(make_item(cau_pkg::OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF,
                                        32'h1, 32'hFFFF_FFFF));
      pending_items.push_back(make_item(cau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 32'h8000_0000));
      pending_items.push_back(make_item(cau_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h1,
                                        32'h1, 32'h1));
      pending_items.push_back(make_item(cau_pkg::OP_DIV, 32'h0003_0000, 32'h0001_0000,
                                        32'h0, 32'h0));
      pending_items.push_back(make_item(cau_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                        32'h1, 32'h0));
      pending_items.push_back(make_item(cau_pkg::OP_DIV, 32'hFFFD_0000, 32'h0002_0000,
                                        32'h0003_0000, 32'hFFFF_0000));
      pending_items.push_back(make_item(cau_pkg::OP_NEG, 32'h8000_0000, 32'h7FFF_FFFF,
                                        32'h0, 32'h0));
      pending_items.push_back(make_item(cau_pkg::OP_CONJ, 32'h8000_0000, 32'h8000_0000,
                                        32'h0, 32'h0));
      pending_items.push_back(make_item(cau_pkg::OP_SQUARE, 32'h7FFF_FFFF, 32'h8000_0000,
                                        32'h0, 32'h0));
      pending_items.push_back(make_item(cau_pkg::OP_NORMSQ, 32'h8000_0000, 32'h8000_0000,
                                        32'h5, 32'h5));
      pending_items.push_back(make_item(cau_pkg::OP_NORMSQ, 32'h0001_8000, 32'hFFFF_FFFF,
                                        32'h0, 32'h0));
      pending_items.push_back(make_item(cau_pkg::OP_RECIP, 32'h0, 32'h0, 32'h0, 32'h0));
      pending_items.push_back(make_item(cau_pkg::OP_RECIP, 32'h1, 32'h0, 32'h0, 32'h0));
      pending_items.push_back(make_item(cau_pkg::OP_RECIP, 32'h0002_0000, 32'hFFFE_0000,
                                        32'h0, 32'h0));
      pending_items.push_back(make_item(cau_pkg::OP_COMPARE, 32'h0001_0000, 32'h0002_0000,
                                        32'h0001_0000, 32'h0002_0000));
      pending_items.push_back(make_item(cau_pkg::OP_COMPARE, 32'h0002_0000, 32'h0001_0000,
                                        32'h0001_0000, 32'h0002_0000));
      pending_items.push_back(make_item(cau_pkg::OP_COMPARE, 32'h8000_0000, 32'h0,
                                        32'h7FFF_FFFF, 32'h0));
      pending_items.push_back(make_item(cau_pkg::OP_COMPARE, 32'h0, 32'h1, 32'h0, 32'h0));
      pending_items.push_back(make_item(cau_pkg::OP_SCALE, 32'h8000_0000, 32'hFFFF_FFFF,
                                        32'h8000_0000, 32'h0));
      pending_items.push_back(make_item(cau_pkg::OP_SHRINK, 32'h0001_0000, 32'h1,
                                        32'h0, 32'h0));
      pending_items.push_back(make_item(cau_pkg::OP_SHRINK, 32'h8000_0000, 32'h7FFF_FFFF,
                                        32'hFFFF_FFFF, 32'h0));
      pending_items.push_back(make_item(cau_pkg::OP_SHRINK, 32'hFFFF_FFFF, 32'h0003_0000,
                                        32'hFFFE_0000, 32'h0));
      for (int c = 12; c < 16; c++)
         pending_items.push_back(make_item(4'(c), 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                           32'hFFFF_FFFF, 32'hFFFF_FFFF));

      // random: defined operations mostly, unused codes now and then;
      // zero divisors and equal operands are steered in on purpose
      for (int n = 0; n < NUM_RANDOM; n++) begin
         pick = $urandom_range(0, 99);
         it = make_item((pick < 94) ? 4'($urandom_range(0, 11)) : 4'($urandom_range(12, 15)),
                        operand_part(), operand_part(), operand_part(), operand_part());
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            it.b_real = '0;
            it.b_imag = '0;
         end else if (pick == 1) begin
            it.a_real = '0;
            it.a_imag = '0;
         end else if (pick == 2) begin
            it.b_real = it.a_real;
            it.b_imag = it.a_imag;
         end else if (pick == 3) begin
            it.b_real = it.a_imag;      // same magnitude, swapped parts
            it.b_imag = it.a_real;
         end
         pending_items.push_back(it);
      end
      total_items = pending_items.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // every item must come back; the drain catches any extra result
      wait (received >= total_items);
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0 && received == total_items) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: complex_arithmetic_unit_top.f
hw/rtl/cau_pkg.sv
hw/rtl/complex_arithmetic_unit_top.sv
tb/sv/testbench.sv
